@@ design/ffha_pkg.sv @@
// shared types and constants for the first-fit heap allocator
`timescale 1ns / 1ps
package ffha_pkg;
  localparam int MaxBlocks   = 64;
  localparam int AddrBits    = 16;
  localparam int HeaderBytes = 16;
  localparam int IdxBits     = $clog2(MaxBlocks);
  localparam int LinkBits    = IdxBits + 1;
  localparam int LimBits     = AddrBits + 1;
  localparam logic [LinkBits-1:0] NilLink = LinkBits'(MaxBlocks);

  typedef enum logic [1:0] {
    StOk       = 2'd0,
    StExhaust  = 2'd1,
    StTabFull  = 2'd2,
    StBadFree  = 2'd3
  } status_e;

  // one table row: start, size, free mark, links
  typedef struct packed {
    logic [AddrBits-1:0] start;
    logic [AddrBits-1:0] bytes;
    logic                is_free;
    logic [LinkBits-1:0] nxt;
    logic [LinkBits-1:0] prv;
  } row_t;

  localparam int RowBits = $bits(row_t);

  typedef enum logic [3:0] {
    CmdNone,
    CmdLoadHead,   // rd addr = head
    CmdFollow,     // rd addr = rd_row.nxt
    CmdTakeFit,    // write cur free=0, result addr
    CmdAppend,     // write new row, result addr, rd old tail
    CmdLinkTail,   // old tail's next = new row
    CmdMarkFree,   // cur.free = 1, rd cur.nxt
    CmdMergeNext,  // cur absorbs next, rd next's next
    CmdFixPrv,     // neighbor's prev = cur, rd cur.prv
    CmdReadPrev,   // rd cur.prv
    CmdMergePrev,  // prev absorbs cur, rd cur.nxt, result ok
    CmdResult      // result with given status, address zero
  } cmd_e;

  typedef struct packed {
    cmd_e    cmd;
    status_e status;
  } ctl_t;

  typedef struct packed {
    logic cur_nil;      // rd pointer is nil
    logic fits;         // rd row free and big enough
    logic addr_match;   // rd row busy and payload matches
    logic slot_avail;
    logic room;
    logic nb_nil;       // neighbor link is nil
    logic nb_free;      // neighbor row is free
    logic tail_nil;     // list is empty
  } sts_t;
endpackage

@@ design/ffha_ram.sv @@
// generic single-port-write ram with registered read
`timescale 1ns / 1ps
module ffha_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];
  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    rdata_o <= mem_q[raddr_i];
  end
endmodule

@@ design/ffha_datapath.sv @@
// block table, list ends, heap top and result registers
`timescale 1ns / 1ps
module ffha_datapath (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         load_i,
  input  logic [15:0]                  req_size_i,
  input  logic [15:0]                  free_address_i,
  input  logic                         cfg_we_i,
  input  logic [16:0]                  cfg_data_i,
  input  ffha_pkg::ctl_t               ctl_i,
  output ffha_pkg::sts_t               sts_o,
  output logic                         valid_o,
  output logic [15:0]                  payload_address_o,
  output logic [1:0]                   status_o
);
  import ffha_pkg::*;

  logic [LimBits-1:0]  limit_q, top_q, top_d;
  logic [AddrBits-1:0] size_q, faddr_q;
  logic [LinkBits-1:0] head_q, head_d, tail_q, tail_d;
  logic [LinkBits-1:0] cur_q, cur_d, nb_q, nb_d;
  logic [MaxBlocks-1:0] used_q, used_d;
  row_t                cur_row_q, cur_row_d, rd_row;
  logic [IdxBits-1:0]  raddr, waddr;
  logic                we;
  row_t                wrow;
  logic [IdxBits-1:0]  free_slot;
  logic                slot_avail;
  logic [LimBits+1:0]  need;
  logic [LimBits-1:0]  lim_eff;
  logic [LimBits-1:0]  pay_full;
  logic [LimBits:0]    merged;
  logic [AddrBits-1:0] merged_sat;
  logic                valid_d;
  logic [15:0]         pa_d;
  logic [1:0]          st_d;
  logic [LinkBits-1:0] rd_ptr_q, rd_ptr_d;

  ffha_ram #(.Width(RowBits), .Depth(MaxBlocks)) u_tab (
    .clk_i, .we_i(we), .waddr_i(waddr), .wdata_i(wrow),
    .raddr_i(raddr), .rdata_o(rd_row)
  );

  always_comb begin
    free_slot  = '0;
    slot_avail = 1'b0;
    for (int i = MaxBlocks - 1; i >= 0; i--) begin
      if (!used_q[i]) begin
        free_slot  = IdxBits'(i);
        slot_avail = 1'b1;
      end
    end
  end

  assign lim_eff = (limit_q > LimBits'(1 << AddrBits)) ? LimBits'(1 << AddrBits) : limit_q;
  assign need    = (LimBits+2)'(top_q) + (LimBits+2)'(HeaderBytes) + (LimBits+2)'(size_q);
  assign pay_full = LimBits'(rd_row.start) + LimBits'(HeaderBytes);
  assign merged  = (LimBits+1)'(cur_row_q.bytes) + (LimBits+1)'(rd_row.bytes)
                 + (LimBits+1)'(HeaderBytes);
  assign merged_sat = (merged > (LimBits+1)'((1 << AddrBits) - 1)) ? '1
                    : merged[AddrBits-1:0];

  assign sts_o.cur_nil    = rd_ptr_q[IdxBits];
  assign sts_o.fits       = rd_row.is_free && (rd_row.bytes >= size_q);
  assign sts_o.addr_match = !rd_row.is_free && (pay_full == LimBits'(faddr_q));
  assign sts_o.slot_avail = slot_avail;
  assign sts_o.room       = need <= (LimBits+2)'(lim_eff);
  assign sts_o.nb_nil     = nb_q[IdxBits];
  assign sts_o.nb_free    = rd_row.is_free;
  assign sts_o.tail_nil   = tail_q[IdxBits];

  always_comb begin
    raddr = rd_ptr_q[IdxBits-1:0];
    rd_ptr_d = rd_ptr_q;
    we = 1'b0; waddr = cur_q[IdxBits-1:0]; wrow = cur_row_q;
    head_d = head_q; tail_d = tail_q; top_d = top_q; used_d = used_q;
    cur_d = cur_q; cur_row_d = cur_row_q; nb_d = nb_q;
    valid_d = 1'b0; pa_d = '0; st_d = StOk;
    case (ctl_i.cmd)
      CmdLoadHead: begin
        rd_ptr_d = head_q; raddr = head_q[IdxBits-1:0];
      end
      CmdFollow: begin
        rd_ptr_d = rd_row.nxt; raddr = rd_row.nxt[IdxBits-1:0];
      end
      CmdTakeFit: begin
        we = 1'b1; waddr = rd_ptr_q[IdxBits-1:0];
        wrow = rd_row; wrow.is_free = 1'b0;
        valid_d = 1'b1; pa_d = pay_full[AddrBits-1:0];
      end
      CmdAppend: begin
        we = 1'b1; waddr = free_slot;
        wrow.start = top_q[AddrBits-1:0]; wrow.bytes = size_q; wrow.is_free = 1'b0;
        wrow.nxt = NilLink; wrow.prv = tail_q;
        used_d[free_slot] = 1'b1;
        if (tail_q[IdxBits]) head_d = {1'b0, free_slot};
        tail_d = {1'b0, free_slot};
        top_d = need[LimBits-1:0];
        // old tail is read here and linked in the next cycle
        cur_d = tail_q; nb_d = {1'b0, free_slot}; raddr = tail_q[IdxBits-1:0];
        valid_d = 1'b1; pa_d = top_q[AddrBits-1:0] + AddrBits'(HeaderBytes);
      end
      CmdLinkTail: begin
        we = 1'b1; waddr = cur_q[IdxBits-1:0]; wrow = rd_row; wrow.nxt = nb_q;
      end
      CmdMarkFree: begin
        cur_d = rd_ptr_q; cur_row_d = rd_row; cur_row_d.is_free = 1'b1;
        we = 1'b1; waddr = rd_ptr_q[IdxBits-1:0]; wrow = cur_row_d;
        nb_d = rd_row.nxt; raddr = rd_row.nxt[IdxBits-1:0];
      end
      CmdMergeNext: begin
        cur_row_d.bytes = merged_sat; cur_row_d.nxt = rd_row.nxt;
        we = 1'b1; wrow = cur_row_d;
        used_d[nb_q[IdxBits-1:0]] = 1'b0;
        if (rd_row.nxt[IdxBits]) tail_d = cur_q;
        nb_d = rd_row.nxt; raddr = rd_row.nxt[IdxBits-1:0];
      end
      CmdFixPrv: begin
        we = 1'b1; waddr = nb_q[IdxBits-1:0]; wrow = rd_row; wrow.prv = cur_q;
        nb_d = cur_row_q.prv; raddr = cur_row_q.prv[IdxBits-1:0];
      end
      CmdReadPrev: begin
        nb_d = cur_row_q.prv; raddr = cur_row_q.prv[IdxBits-1:0];
      end
      CmdMergePrev: begin
        // prev row absorbs current; then current's next becomes prev's next
        we = 1'b1; waddr = nb_q[IdxBits-1:0];
        wrow = rd_row; wrow.bytes = merged_sat; wrow.nxt = cur_row_q.nxt;
        used_d[cur_q[IdxBits-1:0]] = 1'b0;
        if (cur_row_q.nxt[IdxBits]) tail_d = nb_q;
        cur_d = nb_q; nb_d = cur_row_q.nxt; raddr = cur_row_q.nxt[IdxBits-1:0];
        valid_d = 1'b1;
      end
      CmdResult: begin
        valid_d = 1'b1; st_d = ctl_i.status;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= 17'h10000; top_q <= '0; head_q <= NilLink; tail_q <= NilLink;
      used_q <= '0; valid_o <= 1'b0; rd_ptr_q <= NilLink;
    end else begin
      if (cfg_we_i) limit_q <= cfg_data_i;
      top_q <= top_d; head_q <= head_d; tail_q <= tail_d; used_q <= used_d;
      valid_o <= valid_d; rd_ptr_q <= rd_ptr_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      size_q <= req_size_i; faddr_q <= free_address_i;
    end
    cur_q <= cur_d; cur_row_q <= cur_row_d; nb_q <= nb_d;
    payload_address_o <= pa_d; status_o <= st_d;
  end
endmodule

@@ design/ffha_ctrl.sv @@
// sequencer for list walk, append and merge
`timescale 1ns / 1ps
module ffha_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start_i,
  input  logic           mode_i,
  input  ffha_pkg::sts_t sts_i,
  output logic           busy_o,
  output logic           load_o,
  output ffha_pkg::ctl_t ctl_o
);
  import ffha_pkg::*;

  typedef enum logic [2:0] {
    SIdle, SHead, SWalk, SLink, SNextChk, SNextFix, SPrevChk, SPrevFix
  } state_e;

  state_e state_q, state_d;
  logic   mode_q, mode_d;
  logic [IdxBits:0] steps_q, steps_d;

  assign busy_o = state_q != SIdle;
  assign load_o = start_i && !busy_o;

  always_comb begin
    state_d = state_q; mode_d = mode_q; steps_d = steps_q;
    ctl_o.cmd = CmdNone; ctl_o.status = StOk;
    case (state_q)
      SIdle: if (start_i) begin
        mode_d = mode_i; state_d = SHead; steps_d = '0;
      end
      SHead: begin
        ctl_o.cmd = CmdLoadHead; state_d = SWalk;
      end
      SWalk: begin
        if (sts_i.cur_nil || steps_q == (IdxBits+1)'(MaxBlocks)) begin
          ctl_o.cmd = CmdResult; state_d = SIdle;
          if (mode_q) ctl_o.status = StBadFree;
          else if (!sts_i.slot_avail) ctl_o.status = StTabFull;
          else if (!sts_i.room) ctl_o.status = StExhaust;
          else begin
            ctl_o.cmd = CmdAppend;
            if (!sts_i.tail_nil) state_d = SLink;
          end
        end else if (!mode_q && sts_i.fits) begin
          ctl_o.cmd = CmdTakeFit; state_d = SIdle;
        end else if (mode_q && sts_i.addr_match) begin
          ctl_o.cmd = CmdMarkFree; state_d = SNextChk;
        end else begin
          ctl_o.cmd = CmdFollow; steps_d = steps_q + 1'b1;
        end
      end
      SLink: begin
        ctl_o.cmd = CmdLinkTail; state_d = SIdle;
      end
      SNextChk: begin
        if (!sts_i.nb_nil && sts_i.nb_free) begin
          ctl_o.cmd = CmdMergeNext; state_d = SNextFix;
        end else begin
          ctl_o.cmd = CmdReadPrev; state_d = SPrevChk;
        end
      end
      SNextFix: begin
        if (!sts_i.nb_nil) ctl_o.cmd = CmdFixPrv;
        else ctl_o.cmd = CmdReadPrev;
        state_d = SPrevChk;
      end
      SPrevChk: begin
        if (!sts_i.nb_nil && sts_i.nb_free) begin
          ctl_o.cmd = CmdMergePrev; state_d = SPrevFix;
        end else begin
          ctl_o.cmd = CmdResult; ctl_o.status = StOk; state_d = SIdle;
        end
      end
      SPrevFix: begin
        if (!sts_i.nb_nil) ctl_o.cmd = CmdFixPrv;
        state_d = SIdle;
      end
      default: state_d = SIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SIdle; mode_q <= 1'b0; steps_q <= '0;
    end else begin
      state_q <= state_d; mode_q <= mode_d; steps_q <= steps_d;
    end
  end
endmodule

@@ design/first_fit_heap_allocator_unit.sv @@
// top level of the first-fit heap allocator
`timescale 1ns / 1ps
// One item at a time: start is taken at an edge where busy is low, and busy
// stays high while the block list is walked one entry per cycle through the
// registered-read table ram. An allocate either takes the first free block that
// fits or walks all blocks and appends a new one; after an append to a non-empty
// list the old tail is linked to the new row. The table has 64 rows. A free
// walks to the matching block, marks it free and merges each free neighbor; a
// bad free walks the whole list. The result is registered and appears in the
// cycle after the step that makes it, for one cycle with done_o; the receiver
// cannot stall it. The next start is taken at the first edge with busy low.
module first_fit_heap_allocator_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic        mode_i,
  input  logic [15:0] req_size_i,
  input  logic [15:0] free_address_i,
  input  logic        heap_limit_we_i,
  input  logic [16:0] heap_limit_i,
  output logic        done_o,
  output logic [15:0] payload_address_o,
  output logic [1:0]  status_o
);
  import ffha_pkg::*;
  ctl_t ctl;
  sts_t sts;
  logic load;

  ffha_ctrl u_ctrl (
    .clk_i, .rst_ni, .start_i(start), .mode_i, .sts_i(sts),
    .busy_o(busy), .load_o(load), .ctl_o(ctl)
  );

  ffha_datapath u_dp (
    .clk_i, .rst_ni, .load_i(load), .req_size_i, .free_address_i,
    .cfg_we_i(heap_limit_we_i), .cfg_data_i(heap_limit_i),
    .ctl_i(ctl), .sts_o(sts), .valid_o(done_o),
    .payload_address_o, .status_o
  );
endmodule

@@ design/ffha_checker.sv @@
// port-level checks for the allocator, bound to the top level
`timescale 1ns / 1ps
module ffha_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       start,
  input logic       busy,
  input logic       done_o,
  input logic [15:0] payload_address_o,
  input logic [1:0] status_o
);
  import ffha_pkg::*;
  a_busy_after_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |=> busy) else $error("accepted item did not raise busy");
  a_no_done_at_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |=> !done_o) else $error("result in cycle after accept");
  a_err_zero_addr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && status_o != StOk |-> payload_address_o == '0)
    else $error("error result with nonzero address");
  a_done_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o) else $error("two results back to back");
endmodule

bind first_fit_heap_allocator_unit ffha_checker u_ffha_checker (
  .clk_i, .rst_ni, .start, .busy, .done_o, .payload_address_o, .status_o
);

@@ tb/tb_top.sv @@
// testbench for the first-fit heap allocator: self-checking against a behavioral heap model
`timescale 1ns / 1ps
module tb_top;
  import ffha_pkg::*;

  class heap_scoreboard;
    logic [15:0] exp_addr_q[$];
    status_e     exp_stat_q[$];
    int          errors;
    // block table
    bit [15:0]   blk_start[MaxBlocks];
    bit [16:0]   blk_bytes[MaxBlocks];
    bit          blk_free[MaxBlocks];
    bit          blk_used[MaxBlocks];
    int          nxt[MaxBlocks];
    int          prv[MaxBlocks];
    int          head, tail;
    bit [16:0]   top, limit;
    logic [15:0] live_q[$];

    function new();
      for (int i = 0; i < MaxBlocks; i++) begin
        blk_used[i] = 0; blk_free[i] = 0; nxt[i] = MaxBlocks; prv[i] = MaxBlocks;
      end
      head = MaxBlocks; tail = MaxBlocks; top = 0; limit = 17'h10000; errors = 0;
    endfunction

    function void absorb(int keep, int gone);
      int nn;
      int unsigned sum;
      nn = nxt[gone];
      sum = blk_bytes[keep] + blk_bytes[gone] + HeaderBytes;
      blk_bytes[keep] = (sum > 65535) ? 17'd65535 : sum[16:0];
      nxt[keep] = nn;
      if (nn < MaxBlocks) prv[nn] = keep;
      else tail = keep;
      blk_used[gone] = 0;
    endfunction

    function void note_item(bit mode, logic [15:0] size, logic [15:0] faddr);
      int cur, s, n, p, steps;
      int unsigned lim, total;
      logic [15:0] a;
      status_e st;
      a = 0; st = StOk;
      if (!mode) begin
        cur = head; steps = 0;
        while (steps < MaxBlocks && cur < MaxBlocks) begin
          if (blk_free[cur] && blk_bytes[cur] >= size) break;
          cur = nxt[cur]; steps++;
        end
        if (steps < MaxBlocks && cur < MaxBlocks) begin
          blk_free[cur] = 0;
          a = blk_start[cur] + HeaderBytes;
        end else begin
          for (s = 0; s < MaxBlocks; s++) if (!blk_used[s]) break;
          lim = (limit > 17'h10000) ? 32'h10000 : limit;
          total = HeaderBytes + size;
          if (s >= MaxBlocks) st = StTabFull;
          else if (top + total > lim) st = StExhaust;
          else begin
            blk_used[s] = 1; blk_start[s] = top[15:0]; blk_bytes[s] = size;
            blk_free[s] = 0; nxt[s] = MaxBlocks; prv[s] = tail;
            if (tail < MaxBlocks) nxt[tail] = s;
            else head = s;
            tail = s;
            a = blk_start[s] + HeaderBytes;
            top = top + total;
          end
        end
        if (st == StOk) live_q.push_back(a);
      end else begin
        cur = head; steps = 0;
        while (steps < MaxBlocks && cur < MaxBlocks) begin
          if (!blk_free[cur] && blk_start[cur] + HeaderBytes == faddr) break;
          cur = nxt[cur]; steps++;
        end
        if (steps >= MaxBlocks || cur >= MaxBlocks) st = StBadFree;
        else begin
          blk_free[cur] = 1;
          n = nxt[cur];
          if (n < MaxBlocks && blk_free[n]) absorb(cur, n);
          p = prv[cur];
          if (p < MaxBlocks && blk_free[p]) absorb(p, cur);
        end
      end
      exp_addr_q.push_back(a);
      exp_stat_q.push_back(st);
    endfunction

    function void check_result(logic [15:0] addr, logic [1:0] stat);
      if (exp_addr_q.size() == 0) begin
        $error("unexpected item: payload_address %0d status %0d", addr, stat);
        errors++;
        return;
      end
      if (exp_addr_q[0] !== addr) begin
        $error("payload_address expected %0d actual %0d", exp_addr_q[0], addr);
        errors++;
      end
      if (exp_stat_q[0] !== stat) begin
        $error("status expected %0d actual %0d", exp_stat_q[0], stat);
        errors++;
      end
      void'(exp_addr_q.pop_front());
      void'(exp_stat_q.pop_front());
    endfunction
  endclass

  logic        clk_i = 0;
  logic        rst_ni = 0;
  logic        start = 0;
  logic        busy;
  logic        mode_i = 0;
  logic [15:0] req_size_i = 0;
  logic [15:0] free_address_i = 0;
  logic        heap_limit_we_i = 0;
  logic [16:0] heap_limit_i = 0;
  logic        done_o;
  logic [15:0] payload_address_o;
  logic [1:0]  status_o;

  heap_scoreboard sb = new();

  always #5 clk_i = ~clk_i;

  first_fit_heap_allocator_unit i_dut (
    .clk_i, .rst_ni, .start, .busy, .mode_i, .req_size_i, .free_address_i,
    .heap_limit_we_i, .heap_limit_i, .done_o, .payload_address_o, .status_o
  );

  always @(posedge clk_i) if (rst_ni && done_o) sb.check_result(payload_address_o, status_o);

  task automatic idle_gap();
    int n;
    n = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 80) : $urandom_range(0, 3);
    if ($urandom_range(0, 3) == 0) n = 0;
    if (n > 0) begin
      start <= 0;
      repeat (n) @(posedge clk_i);
    end
  endtask

  task automatic send_item(bit mode, logic [15:0] size, logic [15:0] faddr);
    start <= 1; mode_i <= mode; req_size_i <= size; free_address_i <= faddr;
    do @(posedge clk_i); while (busy);
    sb.note_item(mode, size, faddr);
    idle_gap();
  endtask

  task automatic alloc(logic [15:0] size);
    send_item(0, size, 16'($urandom));
  endtask

  task automatic release_item(logic [15:0] faddr);
    send_item(1, 16'($urandom), faddr);
  endtask

  task automatic release_live();
    int k;
    logic [15:0] a;
    if (sb.live_q.size() == 0) begin
      release_item(16'($urandom));
      return;
    end
    k = $urandom_range(0, sb.live_q.size() - 1);
    a = sb.live_q[k];
    sb.live_q.delete(k);
    release_item(a);
  endtask

  task automatic set_limit(logic [16:0] v);
    start <= 0;
    while (sb.exp_addr_q.size() != 0 || busy) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    heap_limit_we_i <= 1; heap_limit_i <= v;
    @(posedge clk_i);
    heap_limit_we_i <= 0;
    sb.limit = v;
  endtask

  initial begin
    int r;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);
    // directed
    release_item(16'd16);
    alloc(16'd0);
    alloc(16'd100);
    alloc(16'd8);
    release_item(16'd16);
    release_item(16'd16);
    release_item(16'd32);
    alloc(16'd0);
    release_item(16'hFFFF);
    alloc(16'hFFFF);
    alloc(16'd50);
    alloc(16'd40);
    release_item(16'd48);
    release_item(16'd164);
    release_item(16'd32);
    set_limit(17'd300);
    alloc(16'd200);
    alloc(16'd20);
    set_limit(17'h1FFFF);
    alloc(16'd20);
    for (int i = 0; i < 70; i++) alloc(16'($urandom_range(0, 4)));
    set_limit(17'd0);
    alloc(16'd0);
    // random phases
    for (int ph = 0; ph < 6; ph++) begin
      for (int i = 0; i < 230; i++) begin
        r = $urandom_range(0, 99);
        if (r < 50) begin
          if ($urandom_range(0, 19) == 0) alloc(16'($urandom));
          else alloc(16'($urandom_range(0, 300)));
        end else if (r < 92) release_live();
        else release_item(16'($urandom));
      end
      case (ph)
        0: set_limit(17'd2000);
        1: set_limit(17'h10000);
        2: set_limit(17'($urandom));
        3: set_limit(17'h1FFFF);
        default: set_limit(17'($urandom_range(0, 65536)));
      endcase
    end
    start <= 0;
    while (sb.exp_addr_q.size() != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
    if (sb.errors == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end

  initial begin
    #20ms;
    $display("Regression FAIL");
    $finish;
  end
endmodule
